### rtl/allc_pkg.sv
package allc_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } allc_op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_BAD   = 2'd2,
      ST_EMPTY = 2'd3
   } allc_status_type;

   typedef enum logic [3:0] {
      S_INIT_HEAD,
      S_INIT_TAIL,
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_RD_DATA,
      S_DEL_A,
      S_DEL_B,
      S_SCAN,
      S_FIN,
      S_REPLY
   } allc_state_type;

   localparam int unsigned HEAD_SLOT  = 0;
   localparam int unsigned TAIL_SLOT  = 1;
   localparam int unsigned FIRST_FREE = 2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [3:0]         node_index;
      logic signed [31:0] value;
   } allc_req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         node_slot;
      logic [3:0]         next_slot;
      logic signed [31:0] key_value;
      logic [3:0]         moved_from;
      logic [4:0]         used_slots;
   } allc_rsp_item_type;

endpackage

### rtl/array_linked_list_compacting.sv
// Singly linked list held in a key memory and a link memory, both synchronous RAMs with
// registered read data and one write and one read port each. Slot 0 is the head sentinel,
// slot 1 the tail sentinel, and used slots stay dense. One item is worked on at a time. A
// delete that does not free the last used slot walks the link memory one slot per cycle
// after unlinking, to redirect every link that points at the last used slot, which is then
// moved into the freed slot. Items that fail a check on acceptance go straight to the
// reply state; a delete with no successor fails after reading the link. Results wait in an
// output register so a new item is taken while the previous result is still stalled.
// After reset the head link and then the tail link are written before the first item
// is accepted.
module array_linked_list_compacting
   import allc_pkg::*;
#(
   parameter int unsigned SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  allc_req_item_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output allc_rsp_item_type rsp_item
);

   localparam int unsigned SW   = $clog2(SLOTS);
   localparam int unsigned CW   = $clog2(SLOTS + 1);
   localparam int unsigned CMPW = (CW > 4) ? CW : 4;

   logic [31:0]   key_mem  [SLOTS];
   logic [SW-1:0] link_mem [SLOTS];

   logic          key_we, key_re, link_we, link_re;
   logic [SW-1:0] key_waddr, key_raddr, link_waddr, link_raddr;
   logic [31:0]   key_wdata;
   logic [SW-1:0] link_wdata;
   logic [31:0]   key_rd_ff;
   logic [SW-1:0] link_rd_ff;

   allc_state_type    state_ff, state_in;
   allc_op_type       op_ff, op_in;
   logic [SW-1:0]     node_ff, node_in;
   logic [31:0]       value_ff, value_in;
   logic [SW-1:0]     gone_ff, gone_in;
   logic [31:0]       removed_ff, removed_in;
   logic [SW-1:0]     last_link_ff, last_link_in;
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   logic [SW-1:0]     pend_idx_ff, pend_idx_in;
   logic [CW-1:0]     fill_ff, fill_in;
   allc_rsp_item_type res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   allc_rsp_item_type rsp_item_ff, rsp_item_in;

   logic [CMPW-1:0] node_ext;
   logic [SW-1:0]   node_addr;
   logic [CW-1:0]   fill_m1;
   logic [SW-1:0]   last_slot;
   logic [SW-1:0]   fill_slot;
   logic            rsp_free;
   allc_op_type     req_op;
   logic            node_bad;

   assign node_ext  = CMPW'(req_item.node_index);
   assign node_addr = node_ext[SW-1:0];
   assign fill_m1   = fill_ff - CW'(1);
   assign last_slot = fill_m1[SW-1:0];
   assign fill_slot = fill_ff[SW-1:0];
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_op    = allc_op_type'(req_item.req_type);
   assign node_bad  = (node_ext >= CMPW'(fill_ff)) ||
                      ((req_op != OP_READ) && (node_ext == CMPW'(TAIL_SLOT)));

   // memories
   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= key_wdata;
      if (key_re) key_rd_ff <= key_mem[key_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_HEAD;
         fill_ff      <= CW'(FIRST_FREE);
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      node_ff      <= node_in;
      value_ff     <= value_in;
      gone_ff      <= gone_in;
      removed_ff   <= removed_in;
      last_link_ff <= last_link_in;
      scan_idx_ff  <= scan_idx_in;
      pend_idx_ff  <= pend_idx_in;
      res_ff       <= res_in;
      rsp_item_ff  <= rsp_item_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      node_in      = node_ff;
      value_in     = value_ff;
      gone_in      = gone_ff;
      removed_in   = removed_ff;
      last_link_in = last_link_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      fill_in      = fill_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      key_we       = 1'b0;
      key_re       = 1'b0;
      link_we      = 1'b0;
      link_re      = 1'b0;
      key_waddr    = gone_ff;
      key_raddr    = node_addr;
      link_waddr   = node_ff;
      link_raddr   = node_addr;
      key_wdata    = key_rd_ff;
      link_wdata   = link_rd_ff;
      req_stall    = (state_ff != S_IDLE);

      unique case (state_ff)
         S_INIT_HEAD: begin
            link_we    = 1'b1;
            link_waddr = SW'(HEAD_SLOT);
            link_wdata = SW'(TAIL_SLOT);
            state_in   = S_INIT_TAIL;
         end
         S_INIT_TAIL: begin
            link_we    = 1'b1;
            link_waddr = SW'(TAIL_SLOT);
            link_wdata = SW'(TAIL_SLOT);
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               node_in  = node_addr;
               value_in = req_item.value;
               res_in   = '{status: ST_OK, node_slot: '0, next_slot: '0, key_value: '0,
                            moved_from: '0, used_slots: 5'(fill_ff)};
               if (req_op == OP_NONE) begin
                  state_in = S_REPLY;
               end else if (node_bad) begin
                  res_in.status    = ST_BAD;
                  res_in.node_slot = req_item.node_index;
                  state_in         = S_REPLY;
               end else if (req_op == OP_INSERT && fill_ff == CW'(SLOTS)) begin
                  res_in.status    = ST_FULL;
                  res_in.node_slot = req_item.node_index;
                  state_in         = S_REPLY;
               end else begin
                  link_re = 1'b1;
                  unique case (req_op)
                     OP_INSERT: state_in = S_INS_RD;
                     OP_DELETE: state_in = S_DEL_A;
                     default: begin
                        key_re   = 1'b1;
                        state_in = S_RD_DATA;
                     end
                  endcase
               end
            end
         end
         S_INS_RD: begin
            link_we    = 1'b1;
            link_waddr = fill_slot;
            link_wdata = link_rd_ff;
            key_we     = 1'b1;
            key_waddr  = fill_slot;
            key_wdata  = value_ff;
            res_in     = '{status: ST_OK, node_slot: 4'(fill_slot),
                           next_slot: 4'(link_rd_ff), key_value: value_ff,
                           moved_from: '0, used_slots: 5'(fill_ff + CW'(1))};
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = fill_slot;
            fill_in    = fill_ff + CW'(1);
            state_in   = S_REPLY;
         end
         S_RD_DATA: begin
            res_in = '{status: ST_OK, node_slot: 4'(node_ff), next_slot: 4'(link_rd_ff),
                       key_value: (node_ff < SW'(FIRST_FREE)) ? '0 : key_rd_ff,
                       moved_from: '0, used_slots: 5'(fill_ff)};
            state_in = S_REPLY;
         end
         S_DEL_A: begin
            if (link_rd_ff < SW'(FIRST_FREE) || CW'(link_rd_ff) >= fill_ff) begin
               res_in = '{status: ST_EMPTY, node_slot: 4'(node_ff), next_slot: '0,
                          key_value: '0, moved_from: '0, used_slots: 5'(fill_ff)};
               state_in = S_REPLY;
            end else begin
               gone_in    = link_rd_ff;
               link_re    = 1'b1;
               link_raddr = link_rd_ff;
               key_re     = 1'b1;
               key_raddr  = link_rd_ff;
               state_in   = S_DEL_B;
            end
         end
         S_DEL_B: begin
            removed_in = key_rd_ff;
            link_we    = 1'b1;
            link_waddr = node_ff;
            link_wdata = link_rd_ff;
            if (gone_ff == last_slot) begin
               fill_in  = fill_m1;
               res_in   = '{status: ST_OK, node_slot: 4'(gone_ff), next_slot: '0,
                            key_value: key_rd_ff, moved_from: 4'(last_slot),
                            used_slots: 5'(fill_m1)};
               state_in = S_REPLY;
            end else begin
               // fetch the key of the slot that will move
               key_re      = 1'b1;
               key_raddr   = last_slot;
               scan_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_idx_ff < fill_ff) begin
               link_re     = 1'b1;
               link_raddr  = scan_idx_ff[SW-1:0];
               pend_in     = 1'b1;
               pend_idx_in = scan_idx_ff[SW-1:0];
               scan_idx_in = scan_idx_ff + CW'(1);
            end
            if (pend_ff) begin
               // redirect links to the last slot toward the freed one
               if (link_rd_ff == last_slot) begin
                  link_we    = 1'b1;
                  link_waddr = pend_idx_ff;
                  link_wdata = gone_ff;
               end
               if (pend_idx_ff == last_slot) begin
                  last_link_in = (link_rd_ff == last_slot) ? gone_ff : link_rd_ff;
               end
            end else if (scan_idx_ff == fill_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            key_we     = 1'b1;
            key_waddr  = gone_ff;
            key_wdata  = key_rd_ff;
            link_we    = 1'b1;
            link_waddr = gone_ff;
            link_wdata = last_link_ff;
            fill_in    = fill_m1;
            res_in     = '{status: ST_OK, node_slot: 4'(gone_ff), next_slot: '0,
                           key_value: removed_ff, moved_from: 4'(last_slot),
                           used_slots: 5'(fill_m1)};
            state_in   = S_REPLY;
         end
         S_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
